// ----- rtl/core/ile_pkg.sv -----
// ============================================================================
// ile_pkg
// Shared types and constants for the indexed list engine.
// ============================================================================
`default_nettype none

package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int OPC_W    = 3;
    localparam int POS_W    = 7;
    localparam int CNTF_W   = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_GET      = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_INDEX_OF = 3'd4,
        OP_REMOVE   = 3'd5,
        OP_POP      = 3'd6,
        OP_CLEAR    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                      opcode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic                     found;
        status_t                  status;
        logic [CNTF_W-1:0]        count;
        logic                     is_empty;
    } rsp_t;

    // Element store access, one write and one read port per cycle.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/ile_ram.sv -----
// ============================================================================
// ile_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
`default_nettype none

module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ile_seq.sv -----
// ============================================================================
// ile_seq
// Request sequencer: element count, shift/search walks over the store,
// result register.
// ============================================================================
`default_nettype none

module ile_seq (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire ile_pkg::req_t                    req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output ile_pkg::rsp_t                         rsp,
    output ile_pkg::mem_cmd_t                     mem,
    input  wire logic [ile_pkg::WORD_W-1:0]       rd_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GET  = 5'b00010,
        S_INS  = 5'b00100,
        S_REM  = 5'b01000,
        S_SRCH = 5'b10000
    } state_t;

    state_t                            state_reg, state_next;
    logic [ile_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                              pend_v_reg, pend_v_next;
    logic                              rsp_valid_reg, rsp_valid_next;

    logic [ile_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic [ile_pkg::ADDR_W-1:0]        pend_addr_reg, pend_addr_next;
    ile_pkg::op_t                      op_reg, op_next;
    logic [ile_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic signed [ile_pkg::WORD_W-1:0] val_reg, val_next;
    ile_pkg::rsp_t                     rsp_reg, rsp_next;

    logic                              accept;
    logic                              full;
    logic                              rsp_load;
    logic signed [ile_pkg::WORD_W-1:0] r_data;
    logic                              r_found;
    ile_pkg::status_t                  r_status;
    logic [ile_pkg::CNT_W-1:0]         idx_m1;
    logic [ile_pkg::CNT_W-1:0]         idx_p1;
    logic                              hit;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == ile_pkg::CNT_W'(ile_pkg::CAPACITY));
    assign idx_m1    = idx_reg - ile_pkg::CNT_W'(1);
    assign idx_p1    = idx_reg + ile_pkg::CNT_W'(1);
    assign hit       = pend_v_reg && ($signed(rd_data) == val_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_v_next    = pend_v_reg;
        pend_addr_next = pend_addr_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        mem            = '0;
        rsp_load       = 1'b0;
        r_data         = '0;
        r_found        = 1'b0;
        r_status       = ile_pkg::ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.opcode;
                    pos_next    = req.position;
                    val_next    = req.value;
                    pend_v_next = 1'b0;
                    case (req.opcode)
                        ile_pkg::OP_APPEND:
                        begin
                            rsp_load = 1'b1;
                            if (full)
                            begin
                                r_status = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem.wr_en   = 1'b1;
                                mem.wr_addr = count_reg[ile_pkg::ADDR_W-1:0];
                                mem.wr_data = $unsigned(req.value);
                                count_next  = count_reg + ile_pkg::CNT_W'(1);
                            end
                        end
                        ile_pkg::OP_INSERT:
                        begin
                            // range is checked before fullness
                            if (32'(req.position) > 32'(count_reg))
                            begin
                                rsp_load = 1'b1;
                                r_status = ile_pkg::ST_BAD_INDEX;
                                r_data   = -32'sd1;
                            end
                            else if (full)
                            begin
                                rsp_load = 1'b1;
                                r_status = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        ile_pkg::OP_GET:
                        begin
                            if (32'(req.position) >= 32'(count_reg))
                            begin
                                rsp_load = 1'b1;
                                r_status = ile_pkg::ST_BAD_INDEX;
                                r_data   = -32'sd1;
                            end
                            else
                            begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = ile_pkg::ADDR_W'(req.position);
                                state_next  = S_GET;
                            end
                        end
                        ile_pkg::OP_CONTAINS, ile_pkg::OP_INDEX_OF:
                        begin
                            idx_next   = '0;
                            state_next = S_SRCH;
                        end
                        ile_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_load = 1'b1;
                                r_status = ile_pkg::ST_EMPTY;
                            end
                            else if (32'(req.position) >= 32'(count_reg))
                            begin
                                rsp_load = 1'b1;
                                r_status = ile_pkg::ST_BAD_INDEX;
                                r_data   = -32'sd1;
                            end
                            else
                            begin
                                idx_next   = ile_pkg::CNT_W'(req.position);
                                state_next = S_REM;
                            end
                        end
                        ile_pkg::OP_POP:
                        begin
                            rsp_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                r_status = ile_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - ile_pkg::CNT_W'(1);
                            end
                        end
                        ile_pkg::OP_CLEAR:
                        begin
                            rsp_load   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            rsp_load   = 1'b1;
                            count_next = '0;
                        end
                    endcase
                end
            end

            S_GET:
            begin
                rsp_load   = 1'b1;
                r_data     = $signed(rd_data);
                state_next = S_IDLE;
            end

            // Shift up, top down: read idx-1 now, write it to idx next cycle.
            S_INS:
            begin
                mem.wr_en   = pend_v_reg;
                mem.wr_addr = pend_addr_reg;
                mem.wr_data = rd_data;
                if (32'(idx_reg) > 32'(pos_reg))
                begin
                    mem.rd_en      = 1'b1;
                    mem.rd_addr    = idx_m1[ile_pkg::ADDR_W-1:0];
                    pend_v_next    = 1'b1;
                    pend_addr_next = idx_reg[ile_pkg::ADDR_W-1:0];
                    idx_next       = idx_m1;
                end
                else if (pend_v_reg)
                begin
                    pend_v_next = 1'b0;
                end
                else
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = ile_pkg::ADDR_W'(pos_reg);
                    mem.wr_data = $unsigned(val_reg);
                    count_next  = count_reg + ile_pkg::CNT_W'(1);
                    rsp_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // Shift down, bottom up: read idx+1 now, write it to idx next cycle.
            S_REM:
            begin
                mem.wr_en   = pend_v_reg;
                mem.wr_addr = pend_addr_reg;
                mem.wr_data = rd_data;
                if (idx_p1 < count_reg)
                begin
                    mem.rd_en      = 1'b1;
                    mem.rd_addr    = idx_p1[ile_pkg::ADDR_W-1:0];
                    pend_v_next    = 1'b1;
                    pend_addr_next = idx_reg[ile_pkg::ADDR_W-1:0];
                    idx_next       = idx_p1;
                end
                else
                begin
                    pend_v_next = 1'b0;
                    count_next  = count_reg - ile_pkg::CNT_W'(1);
                    rsp_load    = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // Linear scan: compare the word read last cycle, fetch the next.
            S_SRCH:
            begin
                if (hit)
                begin
                    rsp_load    = 1'b1;
                    r_found     = 1'b1;
                    r_data      = (op_reg == ile_pkg::OP_CONTAINS) ? 32'sd1
                                  : $signed(32'(pend_addr_reg));
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
                else if (idx_reg < count_reg)
                begin
                    mem.rd_en      = 1'b1;
                    mem.rd_addr    = idx_reg[ile_pkg::ADDR_W-1:0];
                    pend_v_next    = 1'b1;
                    pend_addr_next = idx_reg[ile_pkg::ADDR_W-1:0];
                    idx_next       = idx_p1;
                end
                else
                begin
                    rsp_load    = 1'b1;
                    r_data      = (op_reg == ile_pkg::OP_CONTAINS) ? 32'sd0 : -32'sd1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next  = S_IDLE;
                pend_v_next = 1'b0;
            end
        endcase

        rsp_next.data     = r_data;
        rsp_next.found    = r_found;
        rsp_next.status   = r_status;
        rsp_next.count    = ile_pkg::CNTF_W'(count_next);
        rsp_next.is_empty = (count_next == '0);

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_v_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_v_reg    <= pend_v_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- rtl/core/indexed_list_engine_unit.sv -----
// ============================================================================
// indexed_list_engine_unit
// Ordered list of signed 32-bit words in a 64-entry store with a count.
// ============================================================================
// Usage:
//   Request channel (req_valid/req_ready/req) carries opcode, position and
//   value. Result channel (rsp_valid/rsp_ready/rsp) returns one result per
//   request: data, found, status, count after the operation and is_empty.
//   One request is in flight at a time. req_ready is high when the sequencer
//   is idle and the result register is empty or being drained this cycle.
//   Append, pop, clear and any error result are decided when the request is
//   accepted; get makes one store read; insert at p shifts the entries at
//   and above p up, remove at p shifts those above p down; contains and
//   index_of scan from the front and stop on a hit.
//   The shift and search walks move one store entry per cycle through the
//   single write port and registered read port of the element store.
//   Reset clears the count and control state; store contents are never read
//   above the count, so the store needs no clearing pass.
//   If the receiver stalls, the result holds in its register and no new
//   request is taken until it is accepted.
// ============================================================================
`default_nettype none

module indexed_list_engine_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ile_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ile_pkg::rsp_t      rsp
);

    ile_pkg::mem_cmd_t            mem;
    logic [ile_pkg::WORD_W-1:0]   rd_data;

    // Sequencer: count, shift and search walks, result register.
    ile_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem       (mem),
        .rd_data   (rd_data)
    );

    // Element store.
    ile_ram #(
        .WIDTH (ile_pkg::WORD_W),
        .DEPTH (ile_pkg::CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ile_checker.sv -----
// ============================================================================
// ile_checker
// Port-level checks on the indexed list engine results.
// ============================================================================
`default_nettype none

module ile_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire ile_pkg::rsp_t rsp
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // no request taken while a result waits without being drained
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
        else $error("request accepted while result stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("is_empty disagrees with count");

    a_bad_index_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ile_pkg::ST_BAD_INDEX) |-> (rsp.data == -32'sd1))
        else $error("bad index without -1 data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ile_pkg::ST_FULL)
        |-> (rsp.count == ile_pkg::CNTF_W'(ile_pkg::CAPACITY)) && !rsp.found)
        else $error("full status with count below capacity");

endmodule

bind indexed_list_engine_unit ile_checker u_ile_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// ----- test/testbench.sv -----
// ============================================================================
// testbench
// Self-checking bench for indexed_list_engine_unit. A shadow copy of the list
// predicts every result. Directed corner cases come first, then the list is
// filled to capacity, then a long random run drifts between growing,
// shrinking and churning the list. Random gaps on both channels.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    // Shadow copy of the list plus the queue of results still owed by the DUT.
    class list_shadow;
        logic signed [WORD_W-1:0] list_words [CAPACITY];
        int unsigned              word_count;
        rsp_t                     owed_results [$];
        int unsigned              failures;

        function new();
            word_count = 0;
            failures   = 0;
        endfunction

        // Applies one request to the shadow list and returns the result it owes.
        function rsp_t apply_list_op(req_t r);
            rsp_t        res;
            int unsigned pos;
            int unsigned i;
            res        = '0;
            res.status = ST_OK;
            pos        = r.position;
            case (r.opcode)
                OP_APPEND:
                    if (word_count >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        list_words[word_count] = r.value;
                        word_count++;
                    end
                OP_INSERT:
                    // range check wins over fullness
                    if (pos > word_count)
                    begin
                        res.status = ST_BAD_INDEX;
                        res.data   = -1;
                    end
                    else if (word_count >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        for (i = word_count; i > pos; i--)
                            list_words[i] = list_words[i - 1];
                        list_words[pos] = r.value;
                        word_count++;
                    end
                OP_GET:
                    if (pos >= word_count)
                    begin
                        res.status = ST_BAD_INDEX;
                        res.data   = -1;
                    end
                    else
                        res.data = list_words[pos];
                OP_CONTAINS, OP_INDEX_OF:
                begin
                    res.data = (r.opcode == OP_CONTAINS) ? 0 : -1;
                    for (i = 0; i < word_count; i++)
                    begin
                        if (list_words[i] == r.value)
                        begin
                            res.found = 1'b1;
                            res.data  = (r.opcode == OP_CONTAINS) ? 1 : i;
                            break;
                        end
                    end
                end
                OP_REMOVE:
                    if (word_count == 0)
                        res.status = ST_EMPTY;
                    else if (pos >= word_count)
                    begin
                        res.status = ST_BAD_INDEX;
                        res.data   = -1;
                    end
                    else
                    begin
                        for (i = pos; i + 1 < word_count; i++)
                            list_words[i] = list_words[i + 1];
                        word_count--;
                    end
                OP_POP:
                    if (word_count == 0)
                        res.status = ST_EMPTY;
                    else
                        word_count--;
                default:
                    word_count = 0;
            endcase
            res.count    = CNTF_W'(word_count);
            res.is_empty = (word_count == 0);
            return res;
        endfunction

        function void note_request(req_t r);
            owed_results.push_back(apply_list_op(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (owed_results.size() == 0)
            begin
                $error("result with no request outstanding: data %0d status %0d",
                       got.data, got.status);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            if (got.data !== want.data)
            begin
                $error("data: expected %0d, got %0d", want.data, got.data);
                failures++;
            end
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                failures++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                failures++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
                failures++;
            end
        endfunction
    endclass

    // Which way the random run pushes the list length.
    typedef enum {GROW, SHRINK, CHURN} drift_t;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int GAP_MAX      = 17;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    list_shadow  shadow = new();
    bit          sender_quiet   = 1'b0;
    bit          receiver_quiet = 1'b0;
    int unsigned cycle_count    = 0;

    indexed_list_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic req_t make_req(op_t op, int unsigned pos, logic signed [WORD_W-1:0] val);
        req_t r;
        r.opcode   = op;
        r.position = POS_W'(pos);
        r.value    = val;
        return r;
    endfunction

    // Words: extremes, a small cluster around zero (lots of duplicates, so
    // first-match ordering gets exercised), copies of stored words, or anything.
    function automatic logic signed [WORD_W-1:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return {1'b1, {(WORD_W-1){1'b0}}};
        if (sel == 1)
            return {1'b0, {(WORD_W-1){1'b1}}};
        if (sel <= 4)
            return $urandom_range(0, 8) - 4;
        if (sel <= 6 && shadow.word_count > 0)
            return shadow.list_words[$urandom_range(0, shadow.word_count - 1)];
        return $urandom();
    endfunction

    // Mostly legal positions; one in ten anywhere in 0..CAPACITY.
    function automatic logic [POS_W-1:0] pick_position(op_t op);
        if ($urandom_range(0, 9) == 0)
            return POS_W'($urandom_range(0, CAPACITY));
        if (op == OP_INSERT)
            return POS_W'($urandom_range(0, shadow.word_count));
        if (shadow.word_count == 0)
            return POS_W'($urandom_range(0, CAPACITY));
        return POS_W'($urandom_range(0, shadow.word_count - 1));
    endfunction

    function automatic op_t pick_opcode(drift_t d);
        int unsigned weight [8];
        int unsigned roll;
        int          k;
        // weights in opcode order, each row sums to 100
        case (d)
            GROW:    weight = '{30, 25, 12, 8, 8, 8, 8, 1};
            SHRINK:  weight = '{8, 8, 12, 8, 8, 27, 28, 1};
            default: weight = '{17, 17, 14, 12, 12, 13, 13, 2};
        endcase
        roll = $urandom_range(0, 99);
        for (k = 0; k < 7; k++)
        begin
            if (roll < weight[k])
                return op_t'(k);
            roll -= weight[k];
        end
        return OP_CLEAR;
    endfunction

    function automatic req_t random_request(drift_t d);
        req_t r;
        r.opcode = pick_opcode(d);
        if (r.opcode inside {OP_INSERT, OP_GET, OP_REMOVE})
            r.position = pick_position(r.opcode);
        else
            r.position = POS_W'($urandom_range(0, CAPACITY));   // ignored by the DUT
        // searches mostly look for something that is actually stored
        if (r.opcode inside {OP_CONTAINS, OP_INDEX_OF} && shadow.word_count > 0
            && $urandom_range(0, 9) < 6)
            r.value = shadow.list_words[$urandom_range(0, shadow.word_count - 1)];
        else
            r.value = pick_word();
        return r;
    endfunction

    // Drives one request and returns at the edge it is accepted. Valid is only
    // dropped when a gap is actually taken, so back-to-back requests keep it high.
    task automatic send_request(input req_t r);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        shadow.note_request(r);
    endtask

    // Called right after an accept: valid drops so the last request is not
    // taken twice while the results drain.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (shadow.owed_results.size() != 0)
            @(posedge clk);
    endtask

    // Corner cases: empty list, both ends, out-of-range positions, extremes.
    task automatic run_directed();
        logic signed [WORD_W-1:0] min_word;
        logic signed [WORD_W-1:0] max_word;
        min_word = {1'b1, {(WORD_W-1){1'b0}}};
        max_word = {1'b0, {(WORD_W-1){1'b1}}};
        // every opcode but append on an empty list
        send_request(make_req(OP_GET, 0, 0));
        send_request(make_req(OP_REMOVE, 0, 0));
        send_request(make_req(OP_POP, 0, 0));
        send_request(make_req(OP_CLEAR, 0, 0));
        send_request(make_req(OP_CONTAINS, 0, 0));
        send_request(make_req(OP_INDEX_OF, 0, 0));
        send_request(make_req(OP_INSERT, 1, 7));
        // build [5, max, min, -1, 0]
        send_request(make_req(OP_INSERT, 0, max_word));
        send_request(make_req(OP_APPEND, 0, min_word));
        send_request(make_req(OP_APPEND, 0, -1));
        send_request(make_req(OP_INSERT, 3, 0));
        send_request(make_req(OP_INSERT, 0, 5));
        send_request(make_req(OP_INSERT, 7, 9));        // past the end
        send_request(make_req(OP_GET, 0, 0));
        send_request(make_req(OP_GET, 4, 0));
        send_request(make_req(OP_GET, 5, 0));
        send_request(make_req(OP_GET, CAPACITY, 0));
        send_request(make_req(OP_CONTAINS, 0, -1));
        send_request(make_req(OP_INDEX_OF, 0, min_word));
        send_request(make_req(OP_INDEX_OF, 0, 12345));
        send_request(make_req(OP_REMOVE, 5, 0));        // bad index, non-empty
        send_request(make_req(OP_REMOVE, 0, 0));
        send_request(make_req(OP_REMOVE, 3, 0));
        send_request(make_req(OP_POP, 0, 0));
        send_request(make_req(OP_CLEAR, 0, 0));
    endtask

    // Result side: random stalls, with quiet stretches where ready stays up.
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 128 == 0)
                receiver_quiet = ($urandom_range(0, 3) == 0);
            stall = receiver_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            shadow.check_result(rsp);
            taken++;
        end
    end

    // Request side and end of run.
    initial
    begin
        drift_t      drift;
        int unsigned phase_left;
        int          n;
        drift      = GROW;
        phase_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Fill to capacity with random words, then knock on a full list:
        // append, insert at the end and at the front, get just past the end and at the last entry.
        while (shadow.word_count < CAPACITY)
            send_request(make_req(OP_APPEND, 0, pick_word()));
        send_request(make_req(OP_APPEND, 0, pick_word()));
        send_request(make_req(OP_INSERT, CAPACITY, pick_word()));
        send_request(make_req(OP_INSERT, 0, pick_word()));
        send_request(make_req(OP_GET, CAPACITY, 0));
        send_request(make_req(OP_GET, CAPACITY - 1, 0));

        // hold off until the DUT has answered everything
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                drift        = drift_t'($urandom_range(0, 2));
                phase_left   = $urandom_range(60, 200);
                sender_quiet = ($urandom_range(0, 4) == 0);
            end
            phase_left--;
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            send_request(random_request(drift));
        end

        wait_drained();
        repeat (CAPACITY + 8) @(posedge clk);
        if (shadow.failures == 0 && shadow.owed_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
